### sv/pip_pkg.sv
// Shared types and constants for the point-in-polygon ray-cast block.
// Used by pip_ctrl, pip_dp and point_in_polygon_ray_cast; no dependencies.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 16;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int TOTAL_W = 32;

  localparam logic [CNT_W-1:0]   VCOUNT_RST = CNT_W'(3);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic start;       // latch query point, clear inside flag and address
    logic rd;          // read vertex at current address, advance address
    logic wrap;        // issue closing edge (last vertex to vertex 0)
    logic write_vtx;   // store loaded vertex
    logic clear_cnt;   // zero the inside count
    logic emit_plain;  // load result register for a non-query request
    logic emit_query;  // load result register with the query outcome
  } pip_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_zero;      // no vertices in use
    logic at_last;     // current address is the last vertex in use
    logic pipe_busy;   // edge pipeline still holds work
  } pip_stat_t;

endpackage

### sv/pip_ctrl.sv
// Sequencer for the point-in-polygon block: handshakes and edge walk control.
// Depends on pip_pkg; drives pip_dp through pip_cmd_t, reads pip_stat_t.
module pip_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [pip_pkg::REQ_W-1:0] in_req_type,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pip_pkg::pip_cmd_t         cmd,
  input  pip_pkg::pip_stat_t        stat
);
  import pip_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_WRAP  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  // a query may start while the last result waits; other requests need the slot
  assign in_stall = (state_r != S_IDLE) ||
                    (out_valid_r && out_stall && (in_req_type != REQ_QUERY));
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_LOAD: begin
              cmd.write_vtx  = 1'b1;
              cmd.emit_plain = 1'b1;
            end
            REQ_QUERY: begin
              cmd.start = 1'b1;
              state_nxt = stat.n_zero ? S_DONE : S_WALK;
            end
            REQ_CLEAR: begin
              cmd.clear_cnt  = 1'b1;
              cmd.emit_plain = 1'b1;
            end
            default: cmd.emit_plain = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        cmd.rd = 1'b1;
        if (stat.at_last) state_nxt = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit_query = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit_plain || cmd.emit_query || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/pip_dp.sv
// Datapath for the point-in-polygon block: vertex memory, edge pipeline,
// inside flag, saturating count and result register. Depends on pip_pkg.
module pip_dp #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pip_pkg::pip_cmd_t           cmd,
  output pip_pkg::pip_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [pip_pkg::CNT_W-1:0]   cfg_vertex_count,
  input  logic [pip_pkg::IDX_W-1:0]   in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic                        out_inside_res,
  output logic [pip_pkg::TOTAL_W-1:0] out_inside_total
);
  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;

  // configuration and walk address
  logic [CNT_W-1:0] vcount_r;
  logic [CNT_W-1:0] n_cur;
  logic [AW-1:0]    addr_r;
  logic             idx_ok;

  // query point
  logic signed [C-1:0] tx_r, ty_r;

  // vertex memory, packed {x, y}
  logic [2*C-1:0] vtx_mem [MAX_VERTICES];
  logic [2*C-1:0] rdata_r;
  logic           rd_v_r, rd_first_r, rd_wrap_r;

  // edge endpoints
  logic [2*C-1:0]      cur, prev_r, first_r;
  logic signed [C-1:0] cur_x, cur_y, prev_x, prev_y;
  logic                swap;

  logic                va_r;
  logic signed [C-1:0] ax_r, ay_r, bx_r, by_r;

  logic                 vb_r, span_b_r;
  logic signed [DW-1:0] dx_r, dyt_r, dy_r, dxt_r;

  logic                 vc_r, span_c_r;
  logic signed [PW-1:0] p1_r, p2_r;

  logic               inside_r;
  logic [TOTAL_W-1:0] cnt_r, cnt_inc;

  assign n_cur  = (32'(vcount_r) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_r;
  assign idx_ok = 32'(in_vertex_index) < 32'(MAX_VERTICES);

  assign stat.n_zero    = (n_cur == '0);
  assign stat.at_last   = (32'(addr_r) + 32'd1) == 32'(n_cur);
  assign stat.pipe_busy = rd_v_r || va_r || vb_r || vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
    end else if (cfg_we) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.start) begin
      addr_r <= '0;
    end else if (cmd.rd) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tx_r <= in_point_x;
      ty_r <= in_point_y;
    end
  end

  // memory: write on load, registered read during the walk
  always_ff @(posedge clk) begin
    if (cmd.write_vtx && idx_ok) begin
      vtx_mem[AW'(in_vertex_index)] <= {in_point_x, in_point_y};
    end
    if (cmd.rd) begin
      rdata_r <= vtx_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r     <= 1'b0;
      rd_first_r <= 1'b0;
      rd_wrap_r  <= 1'b0;
    end else begin
      rd_v_r     <= cmd.rd || cmd.wrap;
      rd_first_r <= cmd.rd && (addr_r == '0);
      rd_wrap_r  <= cmd.wrap;
    end
  end

  // closing edge takes vertex 0 again
  assign cur    = rd_wrap_r ? first_r : rdata_r;
  assign cur_x  = cur[2*C-1:C];
  assign cur_y  = cur[C-1:0];
  assign prev_x = prev_r[2*C-1:C];
  assign prev_y = prev_r[C-1:0];
  assign swap   = prev_x > cur_x;

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prev_r <= cur;
      if (rd_first_r) first_r <= cur;
    end
  end

  // stage A: order the edge by x, equal x keeps stored order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= rd_v_r && !rd_first_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= swap ? cur_x  : prev_x;
    ay_r <= swap ? cur_y  : prev_y;
    bx_r <= swap ? prev_x : cur_x;
    by_r <= swap ? prev_y : cur_y;
  end

  // stage B: differences and x-span test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    span_b_r <= (ax_r < tx_r) && (tx_r <= bx_r);
    dx_r     <= DW'(bx_r) - DW'(ax_r);
    dyt_r    <= DW'(ty_r) - DW'(ay_r);
    dy_r     <= DW'(by_r) - DW'(ay_r);
    dxt_r    <= DW'(tx_r) - DW'(ax_r);
  end

  // stage C: cross product terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    span_c_r <= span_b_r;
    p1_r     <= PW'(dx_r) * PW'(dyt_r);
    p2_r     <= PW'(dy_r) * PW'(dxt_r);
  end

  // toggle on each crossing edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (cmd.start) begin
      inside_r <= 1'b0;
    end else if (vc_r && span_c_r && (p1_r <= p2_r)) begin
      inside_r <= !inside_r;
    end
  end

  assign cnt_inc = (inside_r && (cnt_r != TOTAL_MAX)) ? cnt_r + TOTAL_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear_cnt) begin
      cnt_r <= '0;
    end else if (cmd.emit_query) begin
      cnt_r <= cnt_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_plain) begin
      out_inside_res   <= 1'b0;
      out_inside_total <= cmd.clear_cnt ? '0 : cnt_r;
    end else if (cmd.emit_query) begin
      out_inside_res   <= inside_r;
      out_inside_total <= cnt_inc;
    end
  end

endmodule

### sv/point_in_polygon_ray_cast.sv
// Point-in-polygon test by vertical ray casting. Load requests write one
// vertex at a time into an on-chip vertex memory (MAX_VERTICES entries, no
// clearing after reset: read only vertices you have written). A query request
// walks every edge (i, i+1, wrapping from the last vertex to vertex 0) over
// the vertex_count vertices in use, capped at MAX_VERTICES. The walk reads one
// vertex per cycle from the single memory read port, so one edge enters the
// four-stage edge pipeline per cycle; a query holds off other requests through
// the walk, closing edge, drain and result (straight to the result when
// vertex_count is zero). Load, clear and unknown requests leave the block idle.
// Every request returns one result: out_inside_res is 1 only for a query that
// lands inside, out_inside_total is the saturating count of inside queries
// after the request (zero after a clear). A new query is taken while the
// previous result still waits to be taken; other requests wait for the result
// register to free. Write vertex_count through the cfg port only while the
// block is idle; it resets to 3.
module point_in_polygon_ray_cast #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pip_pkg::CNT_W-1:0]    cfg_vertex_count,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pip_pkg::REQ_W-1:0]    in_req_type,
  input  logic [pip_pkg::IDX_W-1:0]    in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  output logic [pip_pkg::TOTAL_W-1:0]  out_inside_total
);
  import pip_pkg::*;

  pip_cmd_t  cmd;
  pip_stat_t stat;
  logic      cfg_we;

  // the register takes a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  pip_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_vertex_count (cfg_vertex_count),
    .in_vertex_index  (in_vertex_index),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_inside_res   (out_inside_res),
    .out_inside_total (out_inside_total)
  );

  // an inside result always comes with a nonzero count
  a_inside_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_inside_total != '0)
    else $error("inside result with zero count");

  // an accepted clear shows up next cycle as an outside result with zero count
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_CLEAR) |=>
      out_valid && !out_inside_res && (out_inside_total == '0))
    else $error("clear request did not produce a zero result");

  // an accepted query stalls the request channel in the cycle after it
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_QUERY) |=> in_stall)
    else $error("request accepted during a query");

endmodule
